/* design/assert_macros.svh */
// Assertion macros used by the checker file kdfp_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/kdfp_pkg.sv */
// Types, constants and key tables of the keyed decimal field parser.
package kdfp_pkg;

	// Scan phase of the parser
	typedef enum logic [2:0] {
		PH_SKIP,
		PH_KEY,
		PH_SIGN,
		PH_DIGITS,
		PH_HALT
	} phase_t;

	// Key candidate bits
	localparam logic [2:0] CAND_PAGE  = 3'b001;
	localparam logic [2:0] CAND_TOTAL = 3'b010;
	localparam logic [2:0] CAND_TIME  = 3'b100;
	localparam logic [2:0] CAND_ALL   = CAND_PAGE | CAND_TOTAL | CAND_TIME;

	localparam logic [2:0] KEY_LEN_MAX   = 3'd7;
	localparam logic [2:0] KEY_LEN_PAGE  = 3'd4;
	localparam logic [2:0] KEY_LEN_TOTAL = 3'd5;
	localparam logic [2:0] KEY_LEN_TIME  = 3'd4;

	// Special characters
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// One input request
	typedef struct packed {
		logic [7:0] byte_value;
		logic       has_byte;
		logic       last;
	} item_t;

	// Held values, also the result of a text
	typedef struct packed {
		logic [63:0] time_value;
		logic [31:0] total_value;
		logic [31:0] page_value;
	} result_t;

	// Character of "page" at position k
	function automatic logic [7:0] page_char(logic [2:0] k);
		case (k)
			3'd0:    return "p";
			3'd1:    return "a";
			3'd2:    return "g";
			3'd3:    return "e";
			default: return 8'h00;
		endcase
	endfunction

	// Character of "total" at position k
	function automatic logic [7:0] total_char(logic [2:0] k);
		case (k)
			3'd0:    return "t";
			3'd1:    return "o";
			3'd2:    return "t";
			3'd3:    return "a";
			3'd4:    return "l";
			default: return 8'h00;
		endcase
	endfunction

	// Character of "time" at position k
	function automatic logic [7:0] time_char(logic [2:0] k);
		case (k)
			3'd0:    return "t";
			3'd1:    return "i";
			3'd2:    return "m";
			3'd3:    return "e";
			default: return 8'h00;
		endcase
	endfunction

endpackage

/* design/kdfp_core.sv */
// Parser state and its update for one byte request.
module kdfp_core import kdfp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	output result_t res
);

	phase_t      phase_q;
	logic [2:0]  klen_q;
	logic [2:0]  cand_q;
	logic        minus_q;
	logic        digit_q;
	logic [63:0] acc_q;
	logic [63:0] neg_q;
	result_t     held_q;

	phase_t      ph;
	logic [2:0]  kl;
	logic [2:0]  cd;
	logic        mn;
	logic        dg;
	logic [63:0] ac;
	logic [63:0] ng;
	result_t     hd;
	logic        used;
	logic        is_digit;
	logic [63:0] dval;

	// Store the finished number under its key, if it has digits
	function automatic result_t commit(result_t h, logic d, logic m, logic [63:0] a,
			logic [63:0] n, logic [2:0] c, logic [2:0] k);
		result_t     r;
		logic [63:0] v;
		r = h;
		v = m ? n : a;
		if (d) begin
			if ((c & CAND_PAGE) != 3'd0 && k == KEY_LEN_PAGE) begin
				r.page_value = v[31:0];
			end else if ((c & CAND_TOTAL) != 3'd0 && k == KEY_LEN_TOTAL) begin
				r.total_value = v[31:0];
			end else if ((c & CAND_TIME) != 3'd0 && k == KEY_LEN_TIME) begin
				r.time_value = v;
			end
		end
		return r;
	endfunction

	assign is_digit = item.byte_value >= CH_ZERO && item.byte_value <= CH_NINE;
	assign dval     = {60'd0, item.byte_value[3:0]};

	// Scan one byte; the magnitude and its negation advance side by side
	always_comb begin
		ph   = phase_q;
		kl   = klen_q;
		cd   = cand_q;
		mn   = minus_q;
		dg   = digit_q;
		ac   = acc_q;
		ng   = neg_q;
		hd   = held_q;
		used = 1'b0;
		if (en && item.has_byte) begin
			if (ph == PH_SIGN) begin
				ph = PH_DIGITS;
				if (item.byte_value == CH_MINUS) begin
					mn   = 1'b1;
					used = 1'b1;
				end
			end
			if (!used && ph == PH_DIGITS) begin
				if (is_digit) begin
					ac   = (acc_q << 3) + (acc_q << 1) + dval;
					ng   = (neg_q << 3) + (neg_q << 1) - dval;
					dg   = 1'b1;
					used = 1'b1;
				end else begin
					hd = commit(hd, dg, mn, ac, ng, cd, kl);
					ph = PH_SKIP;
				end
			end
			if (!used && ph == PH_SKIP) begin
				if (item.byte_value == CH_SPACE || item.byte_value == CH_COMMA) begin
					used = 1'b1;
				end else begin
					ph = PH_KEY;
					kl = 3'd0;
					cd = CAND_ALL;
				end
			end
			if (!used && ph == PH_KEY) begin
				if (item.byte_value == CH_COLON) begin
					ph = PH_SIGN;
					mn = 1'b0;
					dg = 1'b0;
					ac = 64'd0;
					ng = 64'd0;
				end else if (item.byte_value == CH_COMMA) begin
					ph = PH_HALT;
				end else begin
					if (kl >= KEY_LEN_PAGE || page_char(kl) != item.byte_value) begin
						cd = cd & ~CAND_PAGE;
					end
					if (kl >= KEY_LEN_TOTAL || total_char(kl) != item.byte_value) begin
						cd = cd & ~CAND_TOTAL;
					end
					if (kl >= KEY_LEN_TIME || time_char(kl) != item.byte_value) begin
						cd = cd & ~CAND_TIME;
					end
					if (kl < KEY_LEN_MAX) begin
						kl = kl + 3'd1;
					end
				end
			end
		end
		// Close an open number at the end of the text
		if (en && item.last && (ph == PH_SIGN || ph == PH_DIGITS)) begin
			hd = commit(hd, dg, mn, ac, ng, cd, kl);
		end
		res = hd;
	end

	// Advance state; clear everything after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			klen_q  <= 3'd0;
			cand_q  <= CAND_ALL;
			minus_q <= 1'b0;
			digit_q <= 1'b0;
			acc_q   <= 64'd0;
			neg_q   <= 64'd0;
			held_q  <= '0;
		end else if (en) begin
			if (item.last) begin
				phase_q <= PH_SKIP;
				klen_q  <= 3'd0;
				cand_q  <= CAND_ALL;
				minus_q <= 1'b0;
				digit_q <= 1'b0;
				acc_q   <= 64'd0;
				neg_q   <= 64'd0;
				held_q  <= '0;
			end else begin
				phase_q <= ph;
				klen_q  <= kl;
				cand_q  <= cd;
				minus_q <= mn;
				digit_q <= dg;
				acc_q   <= ac;
				neg_q   <= ng;
				held_q  <= hd;
			end
		end
	end

endmodule

/* design/keyed_decimal_field_parser_top.sv */
// Top level of the keyed decimal field parser with its stream handshakes.
//
// The slave channel carries one character of a text value per request: the
// raw byte in s_tdata, s_tuser set when the byte is real (clear only for an
// empty text), s_tlast on the final request of the text. At the last request
// the master channel gives one result: the signed values of the keys page,
// total and time, each zero when absent.
// A request is registered at acceptance in the input register, parsed by the
// byte scanner as it moves on from there (one multiply-by-ten add per cycle)
// and, for a last request, written to the result register, which drives
// m_tvalid and m_tdata.
// One byte is taken every cycle, sustained, unless a last request waits.
// When the receiver stalls, the result holds in the output register; further
// bytes of the next text keep flowing and only a second last request waits
// in the input register, which drops s_tready until the result is taken.
// Reset clears the parser state, the held values and both valid flags; all
// parser state also returns to its reset value after every last byte.
module keyed_decimal_field_parser_top import kdfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // byte_value[7:0]
	input  logic [0:0]   s_tuser,   // has_byte[0]
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata    // page_value[31:0], total_value[63:32], time_value[127:64]
);

	logic    valid_s1;
	item_t   item_s1;
	logic    adv;
	logic    accept;
	logic    m_valid_q;
	result_t res;
	result_t res_q;

	// Move the staged request on unless it is a last byte facing a full output
	assign adv      = valid_s1 && (!item_s1.last || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	// Input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{byte_value: s_tdata, has_byte: s_tuser[0], last: s_tlast};
		end
	end

	kdfp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.res    (res)
	);

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv && item_s1.last) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (adv && item_s1.last) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {res_q.time_value, res_q.total_value, res_q.page_value};

endmodule

/* design/kdfp_checker.sv */
// Port-level checks of the keyed decimal field parser, bound to the top level.
`include "assert_macros.svh"

module kdfp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         s_tlast,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);

	logic last_req;

	assign last_req = s_tvalid && s_tready && s_tlast;

	// A stalled result holds its value
	`ASSERT_NEXT(a_hold_result, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// A rising result valid must be preceded by an accepted last request
	`ASSERT_IMPLY(a_result_latency, clk, arst_n, $rose(m_tvalid), $past(last_req, 2), "result without last request two cycles before")

	// The input side stalls only behind a waiting result
	`ASSERT_IMPLY(a_stall_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready, "input stalled without output backpressure")

endmodule

bind keyed_decimal_field_parser_top kdfp_checker u_kdfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
